@@ design/argon2_block_compress_macros.svh @@
// assertion macros for the argon2 block compression checker
`ifndef ARGON2_BLOCK_COMPRESS_MACROS_SVH
`define ARGON2_BLOCK_COMPRESS_MACROS_SVH

// property checked only outside reset
`define ACMP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property that must also hold across reset
`define ACMP_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ design/acmp_pkg.sv @@
// shared types, constants and functions for the argon2 block compression
`timescale 1ns / 1ps

package acmp_pkg;

   localparam int unsigned WORD_W  = 64;
   localparam int unsigned PAIR_AW = 6;
   localparam int unsigned NPAIRS  = 64;
   localparam int unsigned ROT_A   = 32;
   localparam int unsigned ROT_B   = 24;
   localparam int unsigned ROT_C   = 16;
   localparam int unsigned ROT_D   = 63;

   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [PAIR_AW-1:0] paddr_type;

   typedef enum logic [2:0] {
      VOP_NONE,
      VOP_LOAD,
      VOP_STORE,
      VOP_MIX,
      VOP_ALIGN,
      VOP_UNALIGN
   } vop_type;

   typedef struct packed {
      logic      wr_in;
      logic      first;
      logic      wr_v;
      paddr_type waddr;
      paddr_type raddr;
      vop_type   vop;
      logic [1:0] step;
      logic      rot;
      logic      out_load;
   } cmd_type;

   function automatic word_type blamka(word_type x, word_type y);
      word_type p;
      p = 64'(x[31:0]) * 64'(y[31:0]);
      return x + y + {p[62:0], 1'b0};
   endfunction

   function automatic word_type rotr(word_type w, int unsigned c);
      return (w >> c) | (w << (WORD_W - c));
   endfunction

   // pair address of element j of round rnd: rows first, then interleaved columns
   function automatic paddr_type round_addr(logic [3:0] rnd, logic [2:0] j);
      return rnd[3] ? {j, rnd[2:0]} : {rnd[2:0], j};
   endfunction

endpackage

@@ design/acmp_ctrl.sv @@
// sequencer for load, round and emit phases of the block compression
`timescale 1ns / 1ps

module acmp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_last_pair,
   output acmp_pkg::cmd_type cmd
);
   import acmp_pkg::*;

   typedef enum logic [8:0] {
      S_LOAD    = 9'b000000001,
      S_RLOAD   = 9'b000000010,
      S_MIX     = 9'b000000100,
      S_ALIGN   = 9'b000001000,
      S_UNALIGN = 9'b000010000,
      S_RSTORE  = 9'b000100000,
      S_ERD     = 9'b001000000,
      S_EWAIT   = 9'b010000000,
      S_EHOLD   = 9'b100000000
   } state_type;

   localparam paddr_type  LAST_PAIR = PAIR_AW'(NPAIRS - 1);
   localparam logic [3:0] LOAD_END  = 4'd8;
   localparam logic [3:0] STORE_END = 4'd7;
   localparam logic [3:0] LAST_RND  = 4'd15;

   state_type  state_ff, state_in;
   paddr_type  lc_ff, lc_in;
   paddr_type  pair_ff, pair_in;
   logic [3:0] rnd_ff, rnd_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [2:0] mix_ff, mix_in;
   logic [1:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       last_ff, last_in;

   always_comb begin
      state_in = state_ff;
      lc_in    = lc_ff;
      pair_in  = pair_ff;
      rnd_in   = rnd_ff;
      cnt_in   = cnt_ff;
      mix_in   = mix_ff;
      step_in  = step_ff;
      last_in  = last_ff;
      cmd      = '0;
      cmd.vop  = VOP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.wr_in = 1'b1;
               cmd.first = (lc_ff == '0);
               cmd.waddr = lc_ff;
               lc_in     = lc_ff + 1'b1;
               if (lc_ff == LAST_PAIR) begin
                  state_in = S_RLOAD;
                  rnd_in   = '0;
                  cnt_in   = '0;
               end
            end
         end
         S_RLOAD: begin
            if (cnt_ff != LOAD_END) cmd.raddr = round_addr(rnd_ff, cnt_ff[2:0]);
            if (cnt_ff != '0) cmd.vop = VOP_LOAD;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LOAD_END) begin
               state_in = S_MIX;
               cnt_in   = '0;
               mix_in   = '0;
               step_in  = '0;
            end
         end
         S_MIX: begin
            cmd.vop  = VOP_MIX;
            cmd.step = step_ff;
            cmd.rot  = (step_ff == 2'd3);
            step_in  = step_ff + 1'b1;
            if (step_ff == 2'd3) begin
               mix_in = mix_ff + 1'b1;
               if (mix_ff == 3'd3) state_in = S_ALIGN;
               if (mix_ff == 3'd7) state_in = S_UNALIGN;
            end
         end
         S_ALIGN: begin
            cmd.vop  = VOP_ALIGN;
            state_in = S_MIX;
         end
         S_UNALIGN: begin
            cmd.vop  = VOP_UNALIGN;
            state_in = S_RSTORE;
            cnt_in   = '0;
         end
         S_RSTORE: begin
            cmd.wr_v  = 1'b1;
            cmd.waddr = round_addr(rnd_ff, cnt_ff[2:0]);
            cmd.vop   = VOP_STORE;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == STORE_END) begin
               cnt_in = '0;
               if (rnd_ff == LAST_RND) begin
                  state_in = S_ERD;
                  pair_in  = '0;
               end else begin
                  rnd_in   = rnd_ff + 1'b1;
                  state_in = S_RLOAD;
               end
            end
         end
         S_ERD: begin
            cmd.raddr = pair_ff;
            if (!rsp_valid_ff) state_in = S_EWAIT;
         end
         S_EWAIT: begin
            cmd.out_load = 1'b1;
            last_in      = (pair_ff == LAST_PAIR);
            state_in     = (pair_ff == LAST_PAIR) ? S_LOAD : S_EHOLD;
         end
         S_EHOLD: begin
            if (rsp_ready) begin
               pair_in  = pair_ff + 1'b1;
               state_in = S_ERD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         lc_ff        <= '0;
         pair_ff      <= '0;
         rnd_ff       <= '0;
         cnt_ff       <= '0;
         mix_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lc_ff        <= lc_in;
         pair_ff      <= pair_in;
         rnd_ff       <= rnd_in;
         cnt_ff       <= cnt_in;
         mix_ff       <= mix_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_last_pair = last_ff;

endmodule

@@ design/acmp_dp.sv @@
// block stores, sixteen-word round register and the shared blamka mixing unit
`timescale 1ns / 1ps

module acmp_dp (
   input  logic               clock,
   input  logic               reset,
   input  acmp_pkg::word_type req_prev_lo,
   input  acmp_pkg::word_type req_prev_hi,
   input  acmp_pkg::word_type req_ref_lo,
   input  acmp_pkg::word_type req_ref_hi,
   input  acmp_pkg::word_type req_old_lo,
   input  acmp_pkg::word_type req_old_hi,
   input  logic               req_use_xor,
   input  acmp_pkg::cmd_type  cmd,
   output acmp_pkg::word_type rsp_out_lo,
   output acmp_pkg::word_type rsp_out_hi
);
   import acmp_pkg::*;

   word_type wrk_e_ff [NPAIRS];
   word_type wrk_o_ff [NPAIRS];
   word_type sav_e_ff [NPAIRS];
   word_type sav_o_ff [NPAIRS];
   word_type wrk_e_rd_ff, wrk_o_rd_ff, sav_e_rd_ff, sav_o_rd_ff;
   word_type v_ff [16];
   word_type v_in [16];
   word_type out_lo_ff, out_hi_ff;
   logic     xor_mode_ff;

   logic     xm;
   word_type r_lo, r_hi, t_lo, t_hi;
   word_type mx, my, mz, bx, zx, rz;
   word_type col [4];

   assign xm   = cmd.first ? req_use_xor : xor_mode_ff;
   assign r_lo = req_prev_lo ^ req_ref_lo;
   assign r_hi = req_prev_hi ^ req_ref_hi;
   assign t_lo = xm ? (r_lo ^ req_old_lo) : r_lo;
   assign t_hi = xm ? (r_hi ^ req_old_hi) : r_hi;

   // one mix half step: blamka then xor-rotate
   assign mx = cmd.step[0] ? v_ff[8]  : v_ff[0];
   assign my = cmd.step[0] ? v_ff[12] : v_ff[4];
   assign mz = cmd.step[0] ? v_ff[4]  : v_ff[12];
   assign bx = blamka(mx, my);
   assign zx = mz ^ bx;

   always_comb begin
      case (cmd.step)
         2'd0:    rz = rotr(zx, ROT_A);
         2'd1:    rz = rotr(zx, ROT_B);
         2'd2:    rz = rotr(zx, ROT_C);
         default: rz = rotr(zx, ROT_D);
      endcase
      if (cmd.step[0]) begin
         col[0] = v_ff[0];
         col[1] = rz;
         col[2] = bx;
         col[3] = v_ff[12];
      end else begin
         col[0] = bx;
         col[1] = v_ff[4];
         col[2] = v_ff[8];
         col[3] = rz;
      end
   end

   always_comb begin
      for (int k = 0; k < 16; k++) v_in[k] = v_ff[k];
      case (cmd.vop)
         VOP_LOAD, VOP_STORE: begin
            for (int k = 0; k < 14; k++) v_in[k] = v_ff[k+2];
            v_in[14] = wrk_e_rd_ff;
            v_in[15] = wrk_o_rd_ff;
         end
         VOP_MIX: begin
            for (int r = 0; r < 4; r++) begin
               if (cmd.rot) begin
                  for (int k = 0; k < 3; k++) v_in[4*r+k] = v_ff[4*r+k+1];
                  v_in[4*r+3] = col[r];
               end else begin
                  v_in[4*r] = col[r];
               end
            end
         end
         VOP_ALIGN: begin
            for (int r = 0; r < 4; r++)
               for (int k = 0; k < 4; k++) v_in[4*r+k] = v_ff[4*r + ((k+r) % 4)];
         end
         VOP_UNALIGN: begin
            for (int r = 0; r < 4; r++)
               for (int k = 0; k < 4; k++) v_in[4*r+k] = v_ff[4*r + ((k+4-r) % 4)];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 16; k++) v_ff[k] <= v_in[k];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_in) begin
         wrk_e_ff[cmd.waddr] <= r_lo;
         wrk_o_ff[cmd.waddr] <= r_hi;
      end else if (cmd.wr_v) begin
         wrk_e_ff[cmd.waddr] <= v_ff[0];
         wrk_o_ff[cmd.waddr] <= v_ff[1];
      end
      wrk_e_rd_ff <= wrk_e_ff[cmd.raddr];
      wrk_o_rd_ff <= wrk_o_ff[cmd.raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_in) begin
         sav_e_ff[cmd.waddr] <= t_lo;
         sav_o_ff[cmd.waddr] <= t_hi;
      end
      sav_e_rd_ff <= sav_e_ff[cmd.raddr];
      sav_o_rd_ff <= sav_o_ff[cmd.raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xor_mode_ff <= 1'b0;
      end else if (cmd.wr_in && cmd.first) begin
         xor_mode_ff <= req_use_xor;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_lo_ff <= wrk_e_rd_ff ^ sav_e_rd_ff;
         out_hi_ff <= wrk_o_rd_ff ^ sav_o_rd_ff;
      end
   end

   assign rsp_out_lo = out_lo_ff;
   assign rsp_out_hi = out_hi_ff;

endmodule

@@ design/argon2_block_compress.sv @@
// top level of the argon2 block compression (controller plus datapath)
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | prev, ref, old word pairs, use_xor
//   rsp     | out       | rsp_valid/rsp_ready  | out word pair, last_pair
//
// a block takes 64 input transfers, one per cycle, then 16 rounds (a load of
// 8 pairs, 32 mix steps, 2 realign steps, 8 pair stores), all on the one shared
// blamka unit; then each result pair is read and registered, and the next is
// read only once it is taken; no new block is taken until the final pair is registered
// reset is synchronous; it clears xor mode and all of the sequencer but the
// last-pair flag; the stores hold no reset value, fully written before being read
// a stalled result holds the emit sequence; the final pair may wait in the
// output register while the next block is already loading
`timescale 1ns / 1ps

module argon2_block_compress (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  acmp_pkg::word_type req_prev_lo,
   input  acmp_pkg::word_type req_prev_hi,
   input  acmp_pkg::word_type req_ref_lo,
   input  acmp_pkg::word_type req_ref_hi,
   input  acmp_pkg::word_type req_old_lo,
   input  acmp_pkg::word_type req_old_hi,
   input  logic               req_use_xor,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output acmp_pkg::word_type rsp_out_lo,
   output acmp_pkg::word_type rsp_out_hi,
   output logic               rsp_last_pair
);
   import acmp_pkg::*;

   // command bundle from the sequencer into the datapath
   cmd_type cmd;

   // sequencer: pair counter, round/mix/step counters, result valid
   acmp_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_last_pair (rsp_last_pair),
      .cmd           (cmd)
   );

   // datapath: even/odd word banks, round register, mixing unit, result register
   acmp_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_prev_lo (req_prev_lo),
      .req_prev_hi (req_prev_hi),
      .req_ref_lo  (req_ref_lo),
      .req_ref_hi  (req_ref_hi),
      .req_old_lo  (req_old_lo),
      .req_old_hi  (req_old_hi),
      .req_use_xor (req_use_xor),
      .cmd         (cmd),
      .rsp_out_lo  (rsp_out_lo),
      .rsp_out_hi  (rsp_out_hi)
   );

endmodule

@@ design/acmp_checker.sv @@
// port-level checker for the argon2 block compression, bound to the top level
`timescale 1ns / 1ps
`include "argon2_block_compress_macros.svh"

module acmp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input acmp_pkg::word_type rsp_out_lo,
   input acmp_pkg::word_type rsp_out_hi,
   input logic               rsp_last_pair
);
   import acmp_pkg::*;

   // a stalled result holds
   `ACMP_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_lo) && $stable(rsp_out_hi), "stalled result changed")

   // no input is taken while a block is being emitted
   `ACMP_ASSERT(a_no_load_in_emit, rsp_valid && !rsp_last_pair |-> !req_ready, "input taken during emit")

   // nothing follows the final pair of a block
   `ACMP_ASSERT(a_last_ends, rsp_valid && rsp_ready && rsp_last_pair |=> !rsp_valid, "result after final pair")

   // after reset the block is empty and waits for input
   `ACMP_ASSERT_RST(a_reset_state, reset |=> !rsp_valid && req_ready, "bad state after reset")

endmodule

bind argon2_block_compress acmp_checker u_acmp_checker (.*);

@@ verif/argon2_block_compress_tb.sv @@
// testbench for the argon2 block compression: streamed blocks against a local blamka predictor
`timescale 1ns / 1ps

module argon2_block_compress_tb;
   import acmp_pkg::*;

   // one input transfer: a word pair of each source block plus the xor flag
   typedef struct {
      word_type   prev_lo, prev_hi, ref_lo, ref_hi, old_lo, old_hi;
      logic       use_xor;
      int         pause;   // nonzero: hold off until every expected pair has come
   } pair_in_type;

   typedef struct {
      word_type lo, hi;
      logic     last;
   } pair_out_type;

   localparam int IDLE_LIMIT = 20000;

   logic     clock, reset;
   logic     req_valid, req_ready;
   word_type req_prev_lo, req_prev_hi, req_ref_lo, req_ref_hi, req_old_lo, req_old_hi;
   logic     req_use_xor;
   logic     rsp_valid, rsp_ready;
   word_type rsp_out_lo, rsp_out_hi;
   logic     rsp_last_pair;

   pair_in_type  pending_pairs[$];
   pair_out_type expected_pairs[$];

   // predictor state
   word_type mixed_words[128];
   word_type kept_words[128];
   int       fill_pos;
   logic     xor_sel;

   int  mismatches;
   int  idle_cycles;
   bit  stim_done;
   bit  timed_out;
   int  send_gap, recv_gap;

   argon2_block_compress dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic word_type pick_word();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return {$urandom, $urandom};
   endfunction

   function automatic word_type bm(word_type x, word_type y);
      word_type p;
      p = {32'd0, x[31:0]} * {32'd0, y[31:0]};
      return x + y + (p << 1);
   endfunction

   function automatic word_type ror(word_type w, int c);
      return (w >> c) | (w << (64 - c));
   endfunction

   task automatic quarter(int a, int b, int c, int d);
      mixed_words[a] = bm(mixed_words[a], mixed_words[b]);
      mixed_words[d] = ror(mixed_words[d] ^ mixed_words[a], 32);
      mixed_words[c] = bm(mixed_words[c], mixed_words[d]);
      mixed_words[b] = ror(mixed_words[b] ^ mixed_words[c], 24);
      mixed_words[a] = bm(mixed_words[a], mixed_words[b]);
      mixed_words[d] = ror(mixed_words[d] ^ mixed_words[a], 16);
      mixed_words[c] = bm(mixed_words[c], mixed_words[d]);
      mixed_words[b] = ror(mixed_words[b] ^ mixed_words[c], 63);
   endtask

   task automatic blake_round(int ix[16]);
      quarter(ix[0], ix[4], ix[8],  ix[12]);
      quarter(ix[1], ix[5], ix[9],  ix[13]);
      quarter(ix[2], ix[6], ix[10], ix[14]);
      quarter(ix[3], ix[7], ix[11], ix[15]);
      quarter(ix[0], ix[5], ix[10], ix[15]);
      quarter(ix[1], ix[6], ix[11], ix[12]);
      quarter(ix[2], ix[7], ix[8],  ix[13]);
      quarter(ix[3], ix[4], ix[9],  ix[14]);
   endtask

   // absorb one accepted pair; on the 64th compress and queue the 64 output pairs
   task automatic predict_pair(pair_in_type it);
      int           ix[16];
      word_type     r_lo, r_hi;
      pair_out_type o;
      r_lo = it.prev_lo ^ it.ref_lo;
      r_hi = it.prev_hi ^ it.ref_hi;
      if (fill_pos == 0) xor_sel = it.use_xor;
      mixed_words[2*fill_pos]     = r_lo;
      mixed_words[2*fill_pos + 1] = r_hi;
      kept_words[2*fill_pos]      = xor_sel ? r_lo ^ it.old_lo : r_lo;
      kept_words[2*fill_pos + 1]  = xor_sel ? r_hi ^ it.old_hi : r_hi;
      if (fill_pos != 63) begin
         fill_pos++;
         return;
      end
      fill_pos = 0;
      // rows of 16 consecutive words
      for (int i = 0; i < 8; i++) begin
         for (int j = 0; j < 16; j++) ix[j] = 16*i + j;
         blake_round(ix);
      end
      // interleaved column pairs
      for (int i = 0; i < 8; i++) begin
         for (int j = 0; j < 8; j++) begin
            ix[2*j]     = 2*i + 16*j;
            ix[2*j + 1] = 2*i + 16*j + 1;
         end
         blake_round(ix);
      end
      for (int k = 0; k < 64; k++) begin
         o.lo   = kept_words[2*k] ^ mixed_words[2*k];
         o.hi   = kept_words[2*k + 1] ^ mixed_words[2*k + 1];
         o.last = (k == 63);
         expected_pairs.push_back(o);
      end
   endtask

   // queue one whole block; style 0 random, 1 all zero, 2 all-ones prev and old with zero ref
   task automatic queue_block(int style, int xor_first, bit flip_xor_later, bit hold_first);
      pair_in_type it;
      for (int i = 0; i < 64; i++) begin
         if (style == 1) begin
            it.prev_lo = '0; it.prev_hi = '0; it.ref_lo = '0;
            it.ref_hi = '0;  it.old_lo = '0;  it.old_hi = '0;
         end else if (style == 2) begin
            it.prev_lo = '1; it.prev_hi = '1; it.ref_lo = '0;
            it.ref_hi = '0;  it.old_lo = '1;  it.old_hi = '1;
         end else begin
            it.prev_lo = pick_word(); it.prev_hi = pick_word();
            it.ref_lo  = pick_word(); it.ref_hi  = pick_word();
            it.old_lo  = pick_word(); it.old_hi  = pick_word();
         end
         if (i == 0) it.use_xor = xor_first[0];
         else it.use_xor = flip_xor_later ? 1'($urandom_range(0, 1)) : xor_first[0];
         it.pause = (hold_first && i == 0);
         pending_pairs.push_back(it);
      end
   endtask

   // stimulus: all-ones extreme with xor mode, then both xor modes on random blocks
   initial begin
      fill_pos = 0;
      xor_sel  = 1'b0;
      stim_done = 1'b0;
      queue_block(2, 1, 0, 0);       // all-ones prev and old words, zero ref, xor mode
      queue_block(0, 0, 1, 1);       // xor off at first pair, later flags ignored
      queue_block(0, 1, 1, 0);       // xor on at first pair, later flags ignored
      wait (pending_pairs.size() == 0);
      stim_done = 1'b1;
   end

   // driver: valid held with a stable payload until the transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         automatic bit fired = req_valid && req_ready;
         automatic bit busy  = req_valid && !fired;
         if (fired) begin
            predict_pair(pending_pairs.pop_front());
            send_gap <= pick_gap();
         end
         if (!busy) begin
            if ((fired ? pick_gap() : send_gap) == 0 && pending_pairs.size() > 0 &&
                !(pending_pairs[0].pause && expected_pairs.size() > 0)) begin
               req_valid   <= 1'b1;
               req_prev_lo <= pending_pairs[0].prev_lo;
               req_prev_hi <= pending_pairs[0].prev_hi;
               req_ref_lo  <= pending_pairs[0].ref_lo;
               req_ref_hi  <= pending_pairs[0].ref_hi;
               req_old_lo  <= pending_pairs[0].old_lo;
               req_old_hi  <= pending_pairs[0].old_hi;
               req_use_xor <= pending_pairs[0].use_xor;
            end else begin
               req_valid <= 1'b0;
               if (!fired && send_gap > 0) send_gap <= send_gap - 1;
            end
         end
      end
   end

   // monitor plus receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pairs.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result transfer lo=%h hi=%h", rsp_out_lo, rsp_out_hi);
            end else begin
               automatic pair_out_type e = expected_pairs.pop_front();
               if (e.lo !== rsp_out_lo || e.hi !== rsp_out_hi || e.last !== rsp_last_pair) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result mismatch: expected lo=%h hi=%h last=%b, got lo=%h hi=%h last=%b",
                              e.lo, e.hi, e.last, rsp_out_lo, rsp_out_hi, rsp_last_pair);
               end
            end
         end
         if (recv_gap > 0) begin
            rsp_ready <= 1'b0;
            recv_gap  <= recv_gap - 1;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_valid && rsp_ready) recv_gap <= pick_gap();
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      mismatches = 0;
      timed_out  = 1'b0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      fork
         begin
            wait (stim_done && !req_valid && expected_pairs.size() == 0);
            repeat (200) @(posedge clock);
         end
         begin
            wait (idle_cycles >= IDLE_LIMIT);
            timed_out = 1'b1;
         end
      join_any
      if (timed_out || mismatches > 0 || expected_pairs.size() > 0)
         $display("argon2_block_compress_tb NOT OK");
      else
         $display("argon2_block_compress_tb OK");
      $finish;
   end

endmodule

@@ argon2_block_compress.f @@
+incdir+design
design/acmp_pkg.sv
design/acmp_ctrl.sv
design/acmp_dp.sv
design/argon2_block_compress.sv
design/acmp_checker.sv
verif/argon2_block_compress_tb.sv
